[hdl/hrq_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// hrq_pkg
// Shared types, sizes and register codes of the hysteresis range quantizer.
// ============================================================================
package hrq_pkg;

    localparam int MAX_RANGES   = 8;
    localparam int SAMPLE_WIDTH = 16;
    localparam int THR_WIDTH    = 16;
    localparam int IDX_WIDTH    = 3;
    localparam int NUM_WIDTH    = 4;
    localparam int CFG_WIDTH    = 64;
    localparam int CFG_IDX_BITS = 3;

    // Rising/falling thresholds for ranges 1 .. MAX_RANGES-1, lane k-1 holds range k
    localparam int TABLE_LANES  = MAX_RANGES - 1;
    localparam int TABLE_BITS   = TABLE_LANES * THR_WIDTH;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_RANGES  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_UP_LOW      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_UP_HIGH     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DOWN_LOW    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DOWN_HIGH   = 3'd4;

    typedef logic [IDX_WIDTH-1:0]  idx_t;
    typedef logic [TABLE_BITS-1:0] thr_table_t;

    typedef struct packed {
        idx_t       last_index;
        thr_table_t up_table;
        thr_table_t down_table;
    } cfg_view_t;

endpackage

[hdl/hysteresis_range_quantizer.sv]
`timescale 1ns / 1ps
// ============================================================================
// hysteresis_range_quantizer
// Multi-level quantizer with hysteresis: a sample is placed in a range by a
// rising and a falling threshold table, and the kept range moves only when
// the tables say so.
// ============================================================================
//
//   channel | signals                                 | direction
//   --------+-----------------------------------------+----------
//   input   | in_valid, in_stall, sample              | in
//   output  | out_valid, out_stall, range_index,      | out
//           | rising_index, falling_index             |
//   config  | cfg_write, cfg_index, cfg_data          | in
//
// One item per cycle sustained while the output is not stalled. An item is
// held in the input register and is then compared and folded into the kept
// range on its way into the result register, from which the result leaves.
// The output register decouples the sides, so a new item is taken while a
// result still waits; input stalls only when both registers are full and
// the output is stalled. Reset clears the valid bits, the kept range (0) and
// the config registers (eight ranges, all thresholds zero).
//
module hysteresis_range_quantizer
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    // input item channel
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [hrq_pkg::SAMPLE_WIDTH-1:0] sample,
    // result item channel
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [hrq_pkg::IDX_WIDTH-1:0]           range_index,
    output logic [hrq_pkg::IDX_WIDTH-1:0]           rising_index,
    output logic [hrq_pkg::IDX_WIDTH-1:0]           falling_index,
    // configuration write port
    input  logic                                    cfg_write,
    input  logic [hrq_pkg::CFG_IDX_BITS-1:0]        cfg_index,
    input  logic [hrq_pkg::CFG_WIDTH-1:0]           cfg_data
);

    hrq_pkg::cfg_view_t                      view;

    // Input register stage
    logic                                    in_valid_reg;
    logic                                    in_valid_next;
    logic signed [hrq_pkg::SAMPLE_WIDTH-1:0] sample_reg;

    // Result register stage
    logic                                    out_valid_reg;
    logic                                    out_valid_next;
    hrq_pkg::idx_t                           rising_reg;
    hrq_pkg::idx_t                           falling_reg;

    hrq_pkg::idx_t                           up_idx;
    hrq_pkg::idx_t                           down_idx;

    logic                                    out_ready;
    logic                                    advance;
    logic                                    in_take;

    hrq_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .view      (view)
    );

    // Handshake: result register frees when empty or being taken this cycle
    assign out_ready = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_ready;
    assign in_stall  = in_valid_reg && !out_ready;
    assign in_take   = in_valid && !in_stall;

    // Hold the input item until it can move into the result register
    assign in_valid_next  = in_take || (in_valid_reg && !out_ready);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load only on a handshake, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
            sample_reg <= sample;
        if (advance)
        begin
            rising_reg  <= up_idx;
            falling_reg <= down_idx;
        end
    end

    // Both tables are compared in parallel against the registered sample
    hrq_index_find u_find_up
    (
        .sample     (sample_reg),
        .thr_table  (view.up_table),
        .last_index (view.last_index),
        .index      (up_idx)
    );

    hrq_index_find u_find_down
    (
        .sample     (sample_reg),
        .thr_table  (view.down_table),
        .last_index (view.last_index),
        .index      (down_idx)
    );

    // Kept range advances together with the result register, so its value
    // is the range index of the item currently shown on the output
    hrq_range_update u_range
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .rising_index  (up_idx),
        .falling_index (down_idx),
        .range_index   (range_index)
    );

    assign out_valid     = out_valid_reg;
    assign rising_index  = rising_reg;
    assign falling_index = falling_reg;

endmodule

[hdl/hrq_cfg_regs.sv]
`timescale 1ns / 1ps
// ============================================================================
// hrq_cfg_regs
// Configuration registers; presents the last index of the clamped range count and both tables.
// ============================================================================
module hrq_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [hrq_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [hrq_pkg::CFG_WIDTH-1:0]       cfg_data,
    output hrq_pkg::cfg_view_t                  view
);

    logic [hrq_pkg::NUM_WIDTH-1:0] num_ranges_reg;
    logic [hrq_pkg::CFG_WIDTH-1:0] up_low_reg;
    logic [hrq_pkg::CFG_WIDTH-1:0] up_high_reg;
    logic [hrq_pkg::CFG_WIDTH-1:0] down_low_reg;
    logic [hrq_pkg::CFG_WIDTH-1:0] down_high_reg;
    logic [hrq_pkg::NUM_WIDTH-1:0] num_clamped;
    logic [2*hrq_pkg::CFG_WIDTH-1:0] up_word;
    logic [2*hrq_pkg::CFG_WIDTH-1:0] down_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_ranges_reg <= hrq_pkg::NUM_WIDTH'(hrq_pkg::MAX_RANGES);
            up_low_reg     <= '0;
            up_high_reg    <= '0;
            down_low_reg   <= '0;
            down_high_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                hrq_pkg::REG_NUM_RANGES: num_ranges_reg <= cfg_data[hrq_pkg::NUM_WIDTH-1:0];
                hrq_pkg::REG_UP_LOW:     up_low_reg     <= cfg_data;
                hrq_pkg::REG_UP_HIGH:    up_high_reg    <= cfg_data;
                hrq_pkg::REG_DOWN_LOW:   down_low_reg   <= cfg_data;
                hrq_pkg::REG_DOWN_HIGH:  down_high_reg  <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // Clamp on read: zero counts as one range, anything above the maximum as the maximum
    always_comb
    begin
        num_clamped = num_ranges_reg;
        if (num_ranges_reg == '0)
            num_clamped = hrq_pkg::NUM_WIDTH'(1);
        else if (num_ranges_reg > hrq_pkg::NUM_WIDTH'(hrq_pkg::MAX_RANGES))
            num_clamped = hrq_pkg::NUM_WIDTH'(hrq_pkg::MAX_RANGES);
    end

    assign up_word   = {up_high_reg, up_low_reg};
    assign down_word = {down_high_reg, down_low_reg};

    assign view.last_index = hrq_pkg::IDX_WIDTH'(num_clamped - hrq_pkg::NUM_WIDTH'(1));
    assign view.up_table   = up_word[hrq_pkg::TABLE_BITS-1:0];
    assign view.down_table = down_word[hrq_pkg::TABLE_BITS-1:0];

endmodule

[hdl/hrq_index_find.sv]
`timescale 1ns / 1ps
// ============================================================================
// hrq_index_find
// Parallel threshold compare; picks the first threshold above the sample.
// ============================================================================
module hrq_index_find
(
    input  logic signed [hrq_pkg::SAMPLE_WIDTH-1:0] sample,
    input  hrq_pkg::thr_table_t                     thr_table,
    input  hrq_pkg::idx_t                           last_index,
    output hrq_pkg::idx_t                           index
);

    logic signed [hrq_pkg::THR_WIDTH-1:0] sample_ext;

    assign sample_ext = hrq_pkg::THR_WIDTH'(sample);

    // Walk from the top down so the lowest matching range wins
    always_comb
    begin
        logic signed [hrq_pkg::THR_WIDTH-1:0] lane;
        index = last_index;
        for (int k = hrq_pkg::MAX_RANGES - 1; k >= 1; k--)
        begin
            lane = $signed(thr_table[(k-1)*hrq_pkg::THR_WIDTH +: hrq_pkg::THR_WIDTH]);
            if ((hrq_pkg::IDX_WIDTH'(k) <= last_index) && (sample_ext < lane))
                index = hrq_pkg::IDX_WIDTH'(k - 1);
        end
    end

endmodule

[hdl/hrq_range_update.sv]
`timescale 1ns / 1ps
// ============================================================================
// hrq_range_update
// Holds the kept range and applies the hysteresis rule on each item.
// ============================================================================
module hrq_range_update
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  hrq_pkg::idx_t rising_index,
    input  hrq_pkg::idx_t falling_index,
    output hrq_pkg::idx_t range_index
);

    hrq_pkg::idx_t range_reg;
    hrq_pkg::idx_t range_next;
    hrq_pkg::idx_t dropped;

    always_comb
    begin
        dropped = (falling_index < range_reg) ? falling_index : range_reg;
        if (rising_index == falling_index)
            range_next = rising_index;
        else
            range_next = (rising_index > dropped) ? rising_index : dropped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            range_reg <= '0;
        else if (advance)
            range_reg <= range_next;
    end

    assign range_index = range_reg;

endmodule

[hdl/hrq_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// hrq_checker
// Port-level checks of the hysteresis range quantizer, bound to the top level.
// ============================================================================
module hrq_checker
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic                                    in_stall,
    input  logic signed [hrq_pkg::SAMPLE_WIDTH-1:0] sample,
    input  logic                                    out_valid,
    input  logic                                    out_stall,
    input  logic [hrq_pkg::IDX_WIDTH-1:0]           range_index,
    input  logic [hrq_pkg::IDX_WIDTH-1:0]           rising_index,
    input  logic [hrq_pkg::IDX_WIDTH-1:0]           falling_index
);

    // A stalled input item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(sample))
        else $error("stalled input item changed");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(range_index)
            && $stable(rising_index) && $stable(falling_index))
        else $error("stalled result changed");

    // With an empty output register the input never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    // Agreeing tables force the kept range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (rising_index == falling_index) |-> range_index == rising_index)
        else $error("range not taken from agreeing tables");

    // Kept range lies between the rising index and the larger of the two
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (range_index >= rising_index)
            && ((range_index <= rising_index) || (range_index <= falling_index)))
        else $error("range outside hysteresis band");

endmodule

bind hysteresis_range_quantizer hrq_checker u_hrq_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sample        (sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .range_index   (range_index),
    .rising_index  (rising_index),
    .falling_index (falling_index)
);
